/* rtl/mpu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpu_pkg: shared types and constants of the multi-period phase unwrapper
// Widths, register indexes, fixed-point formats and the structs that run
// between the configuration block, the divider and the unwrap pipeline.
// ----------------------------------------------------------------------------
package mpu_pkg;

  // Map count and input format
  localparam int PHASE_BITS  = 16;
  localparam int NUM_MAPS    = 4;
  localparam int MAX_PERIODS = 4;
  localparam int USED_MAX    = (MAX_PERIODS < NUM_MAPS) ? MAX_PERIODS : NUM_MAPS;
  localparam int NUM_UNITS   = NUM_MAPS - 1;
  localparam int MIN_UNWRAP  = 2;
  localparam int IN_DW       = NUM_MAPS * PHASE_BITS;
  localparam int MAP_W       = $clog2(NUM_MAPS);
  localparam int UNIT_W      = $clog2(NUM_UNITS);

  // Configuration port
  localparam int PER_W  = 16;
  localparam int USED_W = 3;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;
  localparam int CFG_USED        = 0;
  localparam int CFG_PERIOD0     = 1;
  localparam int CFG_PERIOD_LAST = CFG_PERIOD0 + NUM_MAPS - 1;

  // Fixed-point formats
  localparam int FRAC_W     = 16;                      // factor fraction bits
  localparam int TWO_PI_Q16 = 411775;                  // 2*pi in Q.16
  localparam int FAC_W      = 32;                      // period ratio, Q16.16
  localparam int STEP_W     = 31;                      // 2*pi*ratio, Q.12
  localparam int DIV_W      = STEP_W + 1;              // twice the step
  localparam int A_W        = 33;                      // scaled phase
  localparam int U_W        = 34;                      // running unwrapped phase
  localparam int MAG_W      = 34;                      // magnitude of rounding numerator
  localparam int X_W        = MAG_W + 1;
  localparam int PROD_W     = PHASE_BITS + FAC_W + 1;
  localparam int OUT_W      = 32;
  localparam int FACTOR_RST = 1 << FRAC_W;
  localparam int STEP_RST   = (TWO_PI_Q16 + 8) / 16;

  // Constant divider
  localparam int DNUM_W   = 35;
  localparam int DDEN_W   = PER_W + 4;
  localparam int DCNT_W   = $clog2(DNUM_W);
  localparam int JOB_W    = $clog2(2 * NUM_UNITS);
  localparam int JOB_LAST = 2 * NUM_UNITS - 1;

  typedef logic signed [A_W-1:0] a_t;

  // One pixel in flight
  typedef struct packed {
    logic                  mask;
    logic signed [U_W-1:0] u;
    a_t [NUM_UNITS-1:0]    a;      // scaled phases of the maps still to apply
  } pix_t;

  // Derived constants seen by the datapath
  typedef struct packed {
    logic                               busy;
    logic [USED_W-1:0]                  used;
    logic [NUM_UNITS-1:0][FAC_W-1:0]    factor;  // entry i: map i+1
    logic [NUM_UNITS-1:0][STEP_W-1:0]   step;    // entry i: map i
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DNUM_W-1:0] num;
    logic [DDEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DNUM_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/mpu_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpu_div: iterative unsigned divider for the derived constants
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpu_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mpu_pkg::div_req_t req,
  output mpu_pkg::div_rsp_t rsp
);
  import mpu_pkg::*;

  logic [DNUM_W-1:0] num_r, quot_r;
  logic [DDEN_W-1:0] den_r, rem_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              run_r, done_r;
  logic [DDEN_W:0]   trial;
  logic              ge;

  // Shift in the next numerator bit and try the subtract
  assign trial = {rem_r, num_r[DNUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  // Run control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      done_r <= (cnt_r == DCNT_W'(DNUM_W - 1));
      run_r  <= (cnt_r != DCNT_W'(DNUM_W - 1));
      cnt_r  <= cnt_r + DCNT_W'(1);
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r  <= req.num;
      den_r  <= req.den;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (run_r) begin
      num_r  <= {num_r[DNUM_W-2:0], 1'b0};
      rem_r  <= ge ? DDEN_W'(trial - {1'b0, den_r}) : trial[DDEN_W-1:0];
      quot_r <= {quot_r[DNUM_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

/* rtl/mpu_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpu_cfg: configuration registers and derived constants
// Holds the period registers and recomputes the period ratios and phase
// steps on the shared divider after every period write.
// ----------------------------------------------------------------------------
module mpu_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [mpu_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [mpu_pkg::CFG_DW-1:0] cfg_wdata,
  output mpu_pkg::cfg_t              cc
);
  import mpu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_WAIT = 3'b100
  } seq_state_t;

  seq_state_t                      state_r;
  logic [JOB_W-1:0]                job_r;
  logic [USED_W-1:0]               used_r;
  logic [PER_W-1:0]                period_r [NUM_MAPS];
  logic [NUM_UNITS-1:0][FAC_W-1:0] factor_r;
  logic [NUM_UNITS-1:0][STEP_W-1:0] step_r;

  logic             period_wr;
  logic [MAP_W-1:0] widx;
  logic [MAP_W-1:0] midx;
  logic [PER_W-1:0] p0, pp;
  logic             is_step;
  div_req_t         req;
  div_rsp_t         rsp;

  assign period_wr = cfg_we && (cfg_addr inside {[CFG_PERIOD0:CFG_PERIOD_LAST]});
  assign widx      = MAP_W'(cfg_addr - CFG_AW'(CFG_PERIOD0));

  // Pick the operands of the current job: ratios first, then steps
  always_comb begin
    is_step = (job_r >= JOB_W'(NUM_UNITS));
    if (is_step) begin
      midx = MAP_W'(job_r - JOB_W'(NUM_UNITS));
    end else begin
      midx = MAP_W'(job_r + JOB_W'(1));
    end
    p0 = (period_r[0] == '0) ? PER_W'(1) : period_r[0];
    pp = period_r[midx];
    req.start = (state_r == ST_LOAD);
    if (is_step) begin
      req.num = DNUM_W'(pp) * DNUM_W'(TWO_PI_Q16) + (DNUM_W'(p0) << 3);
      req.den = DDEN_W'(p0) << 4;
    end else begin
      req.num = (DNUM_W'(pp) << FRAC_W) + DNUM_W'(p0 >> 1);
      req.den = DDEN_W'(p0);
    end
  end

  mpu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Register writes and the recompute sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r   <= '0;
      used_r  <= USED_W'(1);
      for (int i = 0; i < NUM_MAPS; i++) begin
        period_r[i] <= PER_W'(1);
      end
      for (int i = 0; i < NUM_UNITS; i++) begin
        factor_r[i] <= FAC_W'(FACTOR_RST);
        step_r[i]   <= STEP_W'(STEP_RST);
      end
    end else begin
      if (cfg_we && cfg_addr == CFG_AW'(CFG_USED)) begin
        used_r <= cfg_wdata[USED_W-1:0];
      end
      if (period_wr) begin
        period_r[widx] <= cfg_wdata[PER_W-1:0];
        state_r        <= ST_LOAD;
        job_r          <= '0;
      end else begin
        case (state_r)
          ST_IDLE: begin
            state_r <= ST_IDLE;
          end
          ST_LOAD: begin
            state_r <= ST_WAIT;
          end
          ST_WAIT: begin
            if (rsp.done) begin
              if (is_step) begin
                step_r[UNIT_W'(job_r - JOB_W'(NUM_UNITS))] <=
                  (rsp.quot == '0) ? STEP_W'(1) : rsp.quot[STEP_W-1:0];
              end else begin
                factor_r[UNIT_W'(job_r)] <= rsp.quot[FAC_W-1:0];
              end
              if (job_r == JOB_W'(JOB_LAST)) begin
                state_r <= ST_IDLE;
              end else begin
                job_r   <= job_r + JOB_W'(1);
                state_r <= ST_LOAD;
              end
            end
          end
          default: begin
            state_r <= ST_IDLE;
          end
        endcase
      end
    end
  end

  // Clamp the map count to what the datapath has
  assign cc.busy   = (state_r != ST_IDLE);
  assign cc.used   = (used_r > USED_W'(USED_MAX)) ? USED_W'(USED_MAX) : used_r;
  assign cc.factor = factor_r;
  assign cc.step   = step_r;

endmodule

/* rtl/mpu_unwrap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpu_unwrap: one map of the unwrap, as a pipeline
// Rounds (a - u) to a whole number of steps through a bit-per-stage restoring
// remainder, then moves u onto a: u_new = a + (step - rem) / 2.
// ----------------------------------------------------------------------------
module mpu_unwrap (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       active,
  input  logic [mpu_pkg::STEP_W-1:0] step,
  input  logic                       in_vld,
  input  mpu_pkg::pix_t              in_pix,
  output logic                       out_vld,
  output mpu_pkg::pix_t              out_pix
);
  import mpu_pkg::*;

  localparam int LAST = MAG_W + 1;

  logic [DIV_W-1:0] dvsr;
  logic             vld_r [0:LAST];
  pix_t             pix_r [0:LAST];
  logic             neg_r [0:MAG_W];
  logic [MAG_W-1:0] num_r [0:MAG_W];
  logic [DIV_W-1:0] rem_r [0:MAG_W];

  logic signed [X_W+1:0] a_ext, u_ext, s_ext, x_full;
  logic [X_W-1:0]        x, x_abs;

  assign dvsr = {step, 1'b0};

  // Front: numerator 2*(a - u) + step, split into sign and magnitude
  always_comb begin
    a_ext  = (X_W + 2)'($signed(in_pix.a[0]));
    u_ext  = (X_W + 2)'($signed(in_pix.u));
    s_ext  = $signed({{(X_W + 2 - STEP_W){1'b0}}, step});
    x_full = ((a_ext - u_ext) <<< 1) + s_ext;
    x      = x_full[X_W-1:0];
    x_abs  = x[X_W-1] ? (~x + X_W'(1)) : x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r[0] <= in_pix;
      neg_r[0] <= x[X_W-1];
      num_r[0] <= x_abs[MAG_W-1:0];
      rem_r[0] <= '0;
    end
  end

  // Remainder by twice the step, one bit per stage
  for (genvar k = 1; k <= MAG_W; k++) begin : g_rem
    logic [DIV_W:0] trial;
    logic           ge;

    assign trial = {rem_r[k-1], num_r[k-1][MAG_W-1]};
    assign ge    = trial >= {1'b0, dvsr};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pix_r[k] <= pix_r[k-1];
        neg_r[k] <= neg_r[k-1];
        num_r[k] <= {num_r[k-1][MAG_W-2:0], 1'b0};
        rem_r[k] <= ge ? DIV_W'(trial - {1'b0, dvsr}) : trial[DIV_W-1:0];
      end
    end
  end

  // Back: floor remainder for a negative numerator, then the new u
  logic [DIV_W-1:0]       rem;
  logic signed [DIV_W+1:0] diff;
  logic signed [U_W:0]    un_full;
  pix_t                   nxt_pix;

  always_comb begin
    rem = rem_r[MAG_W];
    if (neg_r[MAG_W] && rem != '0) begin
      diff = $signed({2'b00, rem}) - $signed({3'b000, step});
    end else begin
      diff = $signed({3'b000, step}) - $signed({2'b00, rem});
    end
    un_full = (U_W + 1)'($signed(pix_r[MAG_W].a[0])) + (U_W + 1)'(diff >>> 1);
    nxt_pix      = pix_r[MAG_W];
    nxt_pix.u    = active ? un_full[U_W-1:0] : pix_r[MAG_W].u;
    // Drop the scaled phase just used
    for (int i = 0; i < NUM_UNITS - 1; i++) begin
      nxt_pix.a[i] = pix_r[MAG_W].a[i+1];
    end
    nxt_pix.a[NUM_UNITS-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[LAST] <= 1'b0;
    end else if (adv) begin
      vld_r[LAST] <= vld_r[MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r[LAST] <= nxt_pix;
    end
  end

  assign out_vld = vld_r[LAST];
  assign out_pix = pix_r[LAST];

endmodule

/* rtl/multiperiod_phase_unwrap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiperiod_phase_unwrap: temporal multi-period phase unwrapping
// Per pixel, unwraps the phase of the coarsest fringe map against the finer
// maps and returns a saturated Q19.12 result.
//
//   channel | dir | handshake         | payload
//   in_     | in  | tvalid / tready   | tdata: four Q3.12 phases, tuser: mask
//   out_    | out | tvalid / tready   | tdata: Q19.12 phase, tuser: saturated
//   cfg_    | in  | we (no wait)      | addr: register index, wdata: value
//
// One pixel per cycle while in_tready is high, through the scaling register,
// three unwrap sections of 36 stages each (34 of them one remainder bit) and
// the saturate and output registers. After a period write the constants are
// rebuilt on one shared divider as six quotients in turn; in_tready stays low
// meanwhile and during any cfg write.
// Reset: synchronous, rst_n low; constants come up for all periods = 1.
// Output register plus skid stage: a held result does not stop input; the
// pipeline stops only when the skid stage is full.
// ----------------------------------------------------------------------------
module multiperiod_phase_unwrap (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [mpu_pkg::IN_DW-1:0]  in_tdata,   // phase_zero, phase_one, phase_two,
                                                 // phase_three
  input  logic                       in_tuser,   // pixel_mask
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [mpu_pkg::OUT_W-1:0]  out_tdata,  // unwrapped_phase
  output logic                       out_tuser,  // saturated
  input  logic                       cfg_we,
  input  logic [mpu_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [mpu_pkg::CFG_DW-1:0] cfg_wdata
);
  import mpu_pkg::*;

  cfg_t cc;
  logic adv;
  logic in_acc;

  mpu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cc        (cc)
  );

  // Output buffer state
  logic             out_vld_r, skd_vld_r;
  logic [OUT_W-1:0] out_data_r, skd_data_r;
  logic             out_sat_r, skd_sat_r;

  assign adv       = !skd_vld_r;
  assign in_tready = adv && !cc.busy && !cfg_we;
  assign in_acc    = in_tvalid && in_tready;

  // Scale the finer phases by their period ratios, rounding half up
  pix_t f_pix;
  always_comb begin
    f_pix.mask = in_tuser;
    f_pix.u    = U_W'($signed(in_tdata[PHASE_BITS-1:0]));
    for (int i = 0; i < NUM_UNITS; i++) begin
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] rnd;
      prod = $signed(in_tdata[(i + 1) * PHASE_BITS +: PHASE_BITS]) *
             $signed({1'b0, cc.factor[i]});
      rnd  = prod + $signed(PROD_W'(1 << (FRAC_W - 1)));
      f_pix.a[i] = rnd[FRAC_W + A_W - 1:FRAC_W];
    end
  end

  logic f_vld_r;
  pix_t f_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_pix_r <= f_pix;
    end
  end

  // Unwrap chain, one section per finer map
  logic vld_c [0:NUM_UNITS];
  pix_t pix_c [0:NUM_UNITS];

  assign vld_c[0] = f_vld_r;
  assign pix_c[0] = f_pix_r;

  for (genvar i = 0; i < NUM_UNITS; i++) begin : g_unit
    mpu_unwrap u_unwrap (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .active  (cc.used > USED_W'(i + 1)),
      .step    (cc.step[i]),
      .in_vld  (vld_c[i]),
      .in_pix  (pix_c[i]),
      .out_vld (vld_c[i+1]),
      .out_pix (pix_c[i+1])
    );
  end

  // Mask and saturate
  pix_t             l_pix;
  logic             fits;
  logic [OUT_W-1:0] fin_data;
  logic             fin_sat;

  always_comb begin
    l_pix = pix_c[NUM_UNITS];
    fits  = (&l_pix.u[U_W-1:OUT_W-1]) || !(|l_pix.u[U_W-1:OUT_W-1]);
    if (cc.used >= USED_W'(MIN_UNWRAP) && !l_pix.mask) begin
      fin_data = '0;
      fin_sat  = 1'b0;
    end else if (fits) begin
      fin_data = l_pix.u[OUT_W-1:0];
      fin_sat  = 1'b0;
    end else begin
      fin_data = l_pix.u[U_W-1] ? {1'b1, {(OUT_W - 1){1'b0}}}
                                : {1'b0, {(OUT_W - 1){1'b1}}};
      fin_sat  = 1'b1;
    end
  end

  logic             fin_vld_r;
  logic [OUT_W-1:0] fin_data_r;
  logic             fin_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (adv) begin
      fin_vld_r <= vld_c[NUM_UNITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_data_r <= fin_data;
      fin_sat_r  <= fin_sat;
    end
  end

  // Output register with skid stage
  logic out_take;
  assign out_take = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else if (skd_vld_r) begin
      if (out_take) begin
        out_data_r <= skd_data_r;
        out_sat_r  <= skd_sat_r;
        skd_vld_r  <= 1'b0;
      end
    end else if (fin_vld_r) begin
      if (!out_vld_r || out_take) begin
        out_data_r <= fin_data_r;
        out_sat_r  <= fin_sat_r;
        out_vld_r  <= 1'b1;
      end else begin
        skd_data_r <= fin_data_r;
        skd_sat_r  <= fin_sat_r;
        skd_vld_r  <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // The skid stage only holds an item behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skd_vld_r |-> out_vld_r)
    else $error("skid stage full while output register empty");

  // The skid stage fills only when the held result was not taken
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skd_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid stage filled without an output stall");

  // A period write stops input until the constants are rebuilt
  a_period_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_addr >= CFG_AW'(CFG_PERIOD0) && cfg_addr <= CFG_AW'(CFG_PERIOD_LAST))
      |=> !in_tready)
    else $error("input accepted while constants are stale");

endmodule

/* tb/sv/multiperiod_phase_unwrap_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiperiod_phase_unwrap_test: self-checking bench for the phase unwrapper
// Streams pixels into the unwrapper and predicts each unwrapped phase with an
// exact integer model of the fixed-point unwrap. Output items are compared
// in order against the predictions. Directed pixels cover the special cases.
// Random pixels run under random settings with random idling on both streams,
// one long output stall and one pause of the sender until the pipe drains.
// ----------------------------------------------------------------------------
module multiperiod_phase_unwrap_test;

  localparam int     NMAPS        = mpu_pkg::NUM_MAPS;
  localparam int     PW           = mpu_pkg::PHASE_BITS;
  localparam int     AW           = mpu_pkg::CFG_AW;
  localparam int     DW           = mpu_pkg::CFG_DW;
  localparam int     OW           = mpu_pkg::OUT_W;
  localparam longint RAD_2PI_Q16  = 411775;
  localparam longint I32_MAX      = 64'sd2147483647;
  localparam longint I32_MIN      = -64'sd2147483648;
  localparam int     PIPE_LATENCY = 110;
  localparam int     LONG_HOLD    = 400;
  localparam int     MAX_REPORTS  = 10;
  localparam int     RUN_LIMIT_NS = 2000000;

  typedef logic [NMAPS-1:0][PW-1:0] phase_set_t;

  typedef struct packed {
    logic [OW-1:0] phase;
    logic          clipped;
  } unwrap_t;

  // DUT connections
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [NMAPS*PW-1:0]  in_tdata = '0;   // phase_zero, phase_one, phase_two, phase_three
  logic                 in_tuser = 1'b0; // pixel_mask
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OW-1:0]        out_tdata;       // unwrapped_phase
  logic                 out_tuser;       // saturated
  logic                 cfg_we = 1'b0;
  logic [AW-1:0]        cfg_addr = '0;
  logic [DW-1:0]        cfg_wdata = '0;

  // Predictor copy of the registers and the derived constants
  int unsigned maps_in_use;
  longint      period_len  [NMAPS];
  longint      ratio_q16   [NMAPS];
  longint      fringe_step [NMAPS];

  unwrap_t expected_phases [$];

  // Pacing controls and run statistics
  bit src_idling   = 1'b1;
  bit sink_idling  = 1'b1;
  bit hold_request = 1'b0;
  int pixels_sent  = 0;
  int results_seen = 0;
  int masked_seen  = 0;
  int clipped_seen = 0;
  int settings_run = 0;
  int mismatches   = 0;

  unwrap_t seen_result;
  unwrap_t want_result;

  multiperiod_phase_unwrap uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Floor division for a positive divisor
  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Rebuild period ratios and fringe steps from the period registers
  function automatic void rebuild_ratios();
    longint base;
    base = (period_len[0] == 0) ? 1 : period_len[0];
    for (int k = 0; k < NMAPS; k++) begin
      ratio_q16[k]   = (period_len[k] * 65536 + base / 2) / base;
      fringe_step[k] = (period_len[k] * RAD_2PI_Q16 + base * 8) / (base * 16);
      if (fringe_step[k] < 1) fringe_step[k] = 1;
    end
  endfunction

  // Unwrap one pixel against the finer maps and clip to 32 bits
  function automatic unwrap_t unwrap_pixel(logic pix_ok, phase_set_t phases);
    unwrap_t     r;
    longint      ph, u, a, s, order, f;
    int unsigned used;
    used = (maps_in_use > mpu_pkg::USED_MAX) ? mpu_pkg::USED_MAX : maps_in_use;
    u = longint'($signed(phases[0]));
    if (used >= 2) begin
      if (!pix_ok) begin
        u = 0;
      end else begin
        for (int p = 1; p < used; p++) begin
          ph    = longint'($signed(phases[p]));
          f     = ratio_q16[p];
          a     = ph * (f / 65536) + floor_quot(ph * (f % 65536) + 32768, 65536);
          s     = fringe_step[p-1];
          order = floor_quot(2 * (a - u) + s, 2 * s);
          u     = u + order * s;
        end
      end
    end
    r.clipped = 1'b0;
    if (u > I32_MAX) begin
      u = I32_MAX;
      r.clipped = 1'b1;
    end else if (u < I32_MIN) begin
      u = I32_MIN;
      r.clipped = 1'b1;
    end
    r.phase = u[OW-1:0];
    return r;
  endfunction

  // Wrapped phase: mostly full range or within +-pi, sometimes an extreme
  function automatic logic [PW-1:0] draw_phase();
    int v;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: v = $urandom();
      7:          v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
      default:    v = int'($urandom_range(0, 25736)) - 12868;
    endcase
    return v[PW-1:0];
  endfunction

  function automatic phase_set_t draw_phases();
    phase_set_t ps;
    for (int k = 0; k < NMAPS; k++) ps[k] = draw_phase();
    return ps;
  endfunction

  function automatic logic [DW-1:0] draw_period();
    logic [DW-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = DW'($urandom_range(1, 65535));
      1:       v = DW'($urandom_range(1, 64));
      2:       v = 16'hFFFF;
      3:       v = DW'($urandom_range(0, 1));
      default: v = DW'($urandom_range(100, 4000));
    endcase
    return v;
  endfunction

  function automatic logic [DW-1:0] draw_map_count();
    logic [DW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = 1;
      2, 3:    v = 2;
      4, 5:    v = 3;
      9:       v = DW'($urandom_range(5, 7));
      default: v = 4;
    endcase
    return v;
  endfunction

  // Offer one pixel, wait for acceptance and queue its prediction
  task automatic send_pixel(input logic pix_ok, input phase_set_t phases);
    unwrap_t r;
    if (src_idling && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= phases;
    in_tuser  <= pix_ok;
    do @(posedge clk); while (in_tready !== 1'b1);
    r = unwrap_pixel(pix_ok, phases);
    expected_phases = {expected_phases, r};
    pixels_sent++;
    if (!pix_ok && maps_in_use >= 2) masked_seen++;
    if (r.clipped) clipped_seen++;
  endtask

  // Drop valid and hold until every queued pixel has come out
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_phases.size() != 0) @(negedge clk);
  endtask

  // Write all five registers once the pipe is empty
  task automatic configure(input logic [DW-1:0] used, input logic [DW-1:0] p0,
                           input logic [DW-1:0] p1, input logic [DW-1:0] p2,
                           input logic [DW-1:0] p3);
    logic [DW-1:0] value [NMAPS+1];
    logic [AW-1:0] reg_idx;
    drain_results();
    value[0] = used;
    value[1] = p0;
    value[2] = p1;
    value[3] = p2;
    value[4] = p3;
    for (int i = 0; i <= NMAPS; i++) begin
      reg_idx = (i == 0) ? AW'(mpu_pkg::CFG_USED) : AW'(mpu_pkg::CFG_PERIOD0 + i - 1);
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= reg_idx;
      cfg_wdata <= value[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    maps_in_use = 32'(used[2:0]);
    for (int k = 0; k < NMAPS; k++) period_len[k] = longint'(value[k+1]);
    rebuild_ratios();
    settings_run++;
  endtask

  // Change pacing right after a rising edge so the sink sees it cleanly
  task automatic set_idling(input bit on);
    @(posedge clk);
    src_idling  = on;
    sink_idling = on;
  endtask

  // Reset settings: one map, phase zero passes, mask ignored
  task automatic test_single_map_passthrough();
    send_pixel(1'b1, {16'h1234, 16'h8000, 16'h7FFF, 16'h7FFF});
    send_pixel(1'b0, {16'h0000, 16'h7FFF, 16'h8000, 16'h8000});
    send_pixel(1'b1, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000});
    send_pixel(1'b0, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF});
    // zero maps behaves as one
    configure(0, 3000, 1000, 300, 100);
    send_pixel(1'b0, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    send_pixel(1'b1, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
  endtask

  // Map count beyond the limit is clamped to four maps
  task automatic test_map_limit();
    configure(7, 4000, 1000, 250, 60);
    send_pixel(1'b1, {16'h0400, 16'hF200, 16'h1000, 16'hE000});
    send_pixel(1'b1, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    send_pixel(1'b0, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
  endtask

  // Masked pixels give zero once two or more maps are in use
  task automatic test_masked_pixels();
    for (int used = 2; used <= NMAPS; used++) begin
      configure(DW'(used), 2048, 512, 128, 32);
      send_pixel(1'b0, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
      send_pixel(1'b1, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    end
  endtask

  // Huge period ratios push the result past both 32-bit bounds
  task automatic test_clipping();
    configure(4, 1, 65535, 65535, 65535);
    send_pixel(1'b1, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000});
    send_pixel(1'b1, {16'h8000, 16'h8000, 16'h7FFF, 16'h0000});
    send_pixel(1'b1, draw_phases());
  endtask

  // Zero period zero counts as one; tiny ratios raise the step to one
  task automatic test_degenerate_periods();
    configure(4, 0, 1, 0, 65535);
    send_pixel(1'b1, {16'h3000, 16'hC000, 16'h7FFF, 16'h0800});
    send_pixel(1'b1, {16'h8000, 16'h7FFF, 16'h8000, 16'hF800});
    configure(3, 65535, 1, 2, 65535);
    send_pixel(1'b1, {16'h0000, 16'h7FFF, 16'h8000, 16'h1000});
    send_pixel(1'b1, {16'h0000, 16'h8000, 16'h7FFF, 16'h1000});
  endtask

  // Random pixels under a series of random settings
  task automatic test_random_settings();
    for (int n = 0; n < 8; n++) begin
      configure(draw_map_count(), draw_period(), draw_period(), draw_period(),
                draw_period());
      repeat (85) send_pixel($urandom_range(0, 7) != 0, draw_phases());
    end
  endtask

  // Long output stall fills the pipe, then the sender waits for a full drain
  task automatic test_backpressure();
    configure(4, draw_period(), draw_period(), draw_period(), draw_period());
    set_idling(1'b0);
    hold_request = 1'b1;
    repeat (200) send_pixel($urandom_range(0, 7) != 0, draw_phases());
    drain_results();
    set_idling(1'b1);
    repeat (50) send_pixel($urandom_range(0, 7) != 0, draw_phases());
  endtask

  // Back-to-back stream with both sides always ready
  task automatic test_steady_stream();
    configure(4, DW'($urandom_range(1000, 4000)), DW'($urandom_range(200, 999)),
              DW'($urandom_range(40, 199)), DW'($urandom_range(1, 39)));
    set_idling(1'b0);
    repeat (100) send_pixel($urandom_range(0, 7) != 0, draw_phases());
  endtask

  // Output ready: random stalls, plus one long hold counted here
  initial begin : sink_pacing
    int gap;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_tready <= 1'b1;
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 18);
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each output item with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      seen_result.phase   = out_tdata;
      seen_result.clipped = out_tuser;
      results_seen++;
      if (expected_phases.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d: unexpected output phase %0d clip %0b", results_seen,
                   $signed(seen_result.phase), seen_result.clipped);
      end else begin
        want_result = expected_phases.pop_front();
        if (seen_result.phase !== want_result.phase ||
            seen_result.clipped !== want_result.clipped) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected phase %0d clip %0b, got phase %0d clip %0b",
                     results_seen, $signed(want_result.phase), want_result.clipped,
                     $signed(seen_result.phase), seen_result.clipped);
        end
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("multiperiod_phase_unwrap_test NOT OK");
    $finish;
  end

  initial begin : run_tests
    maps_in_use = 1;
    for (int k = 0; k < NMAPS; k++) period_len[k] = 1;
    rebuild_ratios();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_single_map_passthrough();
    test_map_limit();
    test_masked_pixels();
    test_clipping();
    test_degenerate_periods();
    test_random_settings();
    test_backpressure();
    test_steady_stream();

    // let the pipe empty, then watch for stray output items
    drain_results();
    repeat (PIPE_LATENCY + 20) @(negedge clk);

    $display("ran %0d pixels over %0d register settings: %0d masked, %0d clipped",
             pixels_sent, settings_run, masked_seen, clipped_seen);
    $display("map counts 0 to 7, periods 0/1/65535, %0d-cycle output stall, %0d mismatches",
             LONG_HOLD, mismatches);
    if (mismatches == 0 && expected_phases.size() == 0)
      $display("multiperiod_phase_unwrap_test OK");
    else
      $display("multiperiod_phase_unwrap_test NOT OK");
    $finish;
  end

endmodule

/* files.f */
rtl/mpu_pkg.sv
rtl/mpu_div.sv
rtl/mpu_cfg.sv
rtl/mpu_unwrap.sv
rtl/multiperiod_phase_unwrap.sv
tb/sv/multiperiod_phase_unwrap_test.sv
